// File: hdl/spe_pkg.sv
// Shared constants for the sinusoidal position encoder.
`default_nettype none
package spe_pkg;
  localparam int unsigned DEF_MAX_EMBED     = 1024;
  localparam int unsigned DEF_POS_BITS      = 16;
  localparam int unsigned DEF_OUT_FRAC_BITS = 15;
  localparam int unsigned CFG_W             = 11;
  localparam int unsigned K_W               = 9;
  localparam int unsigned SUM_W             = 36;
  localparam int unsigned EXP_TERMS         = 13;
  localparam int unsigned TRIG_STEPS        = 6;
  localparam int unsigned DIV_BITS_PER_STG  = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd512;
  localparam logic [31:0] L2T   = 32'd3566893132;
  localparam logic [31:0] LN2   = 32'hB17217F8;
  localparam logic [31:0] KH    = 32'h28BE60DB;
  localparam logic [31:0] KL    = 32'h9391054A;
  localparam logic [32:0] HPI   = 33'h1_921F_B544;
  localparam logic [32:0] ONE32 = 33'h1_0000_0000;
endpackage
`default_nettype wire

// File: hdl/spe_in_if.sv
// Input channel: sequence position and pair index.
`default_nettype none
interface spe_in_if #(
  parameter int unsigned POS_BITS = spe_pkg::DEF_POS_BITS
);
  logic                      valid;
  logic                      ready;
  logic [POS_BITS-1:0]       position;
  logic [spe_pkg::K_W-1:0]   pair_index;
  modport source (output valid, position, pair_index, input ready);
  modport sink   (input valid, position, pair_index, output ready);
endinterface
`default_nettype wire

// File: hdl/spe_out_if.sv
// Result channel: sine, cosine and status of one element pair.
`default_nettype none
interface spe_out_if #(
  parameter int unsigned OUT_FRAC_BITS = spe_pkg::DEF_OUT_FRAC_BITS
);
  logic                           valid;
  logic                           ready;
  logic signed [OUT_FRAC_BITS:0]  sin_value;
  logic signed [OUT_FRAC_BITS:0]  cos_value;
  logic                           cos_present;
  logic                           index_error;
  modport source (output valid, sin_value, cos_value, cos_present, index_error, input ready);
  modport sink   (input valid, sin_value, cos_value, cos_present, index_error, output ready);
endinterface
`default_nettype wire

// File: hdl/spe_divider.sv
// Pipelined restoring divider giving a 32-bit fraction quotient num/den.
`default_nettype none
module spe_divider #(
  parameter int unsigned DW     = 11,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              v_in,
  input  logic [DW-1:0]     num,
  input  logic [DW-1:0]     den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              v_out,
  output logic [31:0]       quo,
  output logic [SIDE_W-1:0] side_out
);
  import spe_pkg::*;
  localparam int unsigned BPS = DIV_BITS_PER_STG;
  localparam int unsigned NST = 32 / BPS;

  logic              v_a    [0:NST];
  logic [DW-1:0]     rem_a  [0:NST];
  logic [31:0]       quo_a  [0:NST];
  logic [SIDE_W-1:0] side_a [0:NST];

  assign v_a[0]    = v_in;
  assign rem_a[0]  = num;
  assign quo_a[0]  = '0;
  assign side_a[0] = side_in;

  for (genvar s = 0; s < NST; s++) begin : g_stg
    logic [DW-1:0] rem_c;
    logic [31:0]   quo_c;
    logic          v_r;
    logic [DW-1:0] rem_r;
    logic [31:0]   quo_r;
    logic [SIDE_W-1:0] side_r;

    always_comb begin
      logic [DW:0] sh;
      rem_c = rem_a[s];
      quo_c = quo_a[s];
      for (int b = 0; b < BPS; b++) begin
        sh = {rem_c, 1'b0};
        if (sh >= {1'b0, den}) begin
          rem_c = DW'(sh - {1'b0, den});
          quo_c = {quo_c[30:0], 1'b1};
        end else begin
          rem_c = DW'(sh);
          quo_c = {quo_c[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_a[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_c;
        quo_r  <= quo_c;
        side_r <= side_a[s];
      end
    end

    assign v_a[s+1]    = v_r;
    assign rem_a[s+1]  = rem_r;
    assign quo_a[s+1]  = quo_r;
    assign side_a[s+1] = side_r;
  end

  assign v_out    = v_a[NST];
  assign quo      = quo_a[NST];
  assign side_out = side_a[NST];
endmodule
`default_nettype wire

// File: hdl/spe_taylor_step.sv
// One series term: multiply, divide by a constant, accumulate (DIV of zero passes term and sum through); three stages.
`default_nettype none
module spe_taylor_step #(
  parameter int unsigned DIV    = 2,
  parameter bit          NEG    = 1'b0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               v_in,
  input  logic [31:0]                        term_in,
  input  logic [31:0]                        op_in,
  input  logic signed [spe_pkg::SUM_W-1:0]   sum_in,
  input  logic [SIDE_W-1:0]                  side_in,
  output logic                               v_out,
  output logic [31:0]                        term_out,
  output logic [31:0]                        op_out,
  output logic signed [spe_pkg::SUM_W-1:0]   sum_out,
  output logic [SIDE_W-1:0]                  side_out
);
  import spe_pkg::*;
  localparam bit          BYPASS = (DIV == 0);
  localparam logic [63:0] RECIP64 = (64'd1 << 32) / ((DIV == 0) ? 64'd1 : 64'(DIV));
  localparam logic [31:0] RECIP = RECIP64[31:0];
  localparam logic [31:0] DIV_W = 32'(DIV);

  logic              va_r, vb_r, vc_r;
  logic [31:0]       xa_r, opa_r, q0b_r, xb_r, opb_r, termc_r, opc_r;
  logic signed [SUM_W-1:0] suma_r, sumb_r, sumc_r;
  logic [SIDE_W-1:0] sidea_r, sideb_r, sidec_r;

  logic [63:0]       prod_a, prod_b;
  logic [31:0]       xa_nxt, rem_c, q_c, termc_nxt;
  logic signed [SUM_W-1:0] qs_c, sumc_nxt;

  always_comb begin
    prod_a    = {32'b0, term_in} * {32'b0, op_in};
    xa_nxt    = BYPASS ? term_in : prod_a[63:32];
    prod_b    = {32'b0, xa_r} * {32'b0, RECIP};
    rem_c     = xb_r - 32'(q0b_r * DIV_W);
    q_c       = (rem_c >= DIV_W) ? q0b_r + 32'd1 : q0b_r;
    qs_c      = $signed({{(SUM_W-32){1'b0}}, q_c});
    termc_nxt = BYPASS ? xb_r : q_c;
    if (BYPASS) begin
      sumc_nxt = sumb_r;
    end else if (NEG) begin
      sumc_nxt = sumb_r - qs_c;
    end else begin
      sumc_nxt = sumb_r + qs_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= v_in;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa_r    <= xa_nxt;
      opa_r   <= op_in;
      suma_r  <= sum_in;
      sidea_r <= side_in;
      q0b_r   <= prod_b[63:32];
      xb_r    <= xa_r;
      opb_r   <= opa_r;
      sumb_r  <= suma_r;
      sideb_r <= sidea_r;
      termc_r <= termc_nxt;
      opc_r   <= opb_r;
      sumc_r  <= sumc_nxt;
      sidec_r <= sideb_r;
    end
  end

  assign v_out    = vc_r;
  assign term_out = termc_r;
  assign op_out   = opc_r;
  assign sum_out  = sumc_r;
  assign side_out = sidec_r;
endmodule
`default_nettype wire

// File: hdl/sinusoidal_position_encoding_top.sv
// Sinusoidal position encoder top level: one sin/cos element pair per transfer.
// Takes one (position, pair_index) transfer per cycle while the chain advances and
// returns sin and cos of position / 10000^(2k/d) in signed Q1.OUT_FRAC_BITS. The
// chain is an input register, an 8-stage divider for 2k/d, two multiplier stages,
// twelve exp series steps of three stages each, six stages for scale, phase and
// octant fold, two angle stages, six sin/cos series steps of three stages each
// (run side by side) and two output stages. The whole chain advances whenever the
// output register is empty or its transfer completes, so a held result stalls
// every stage at once. Pairs with 2k >= d return zeros with index_error set; the
// last pair of an odd d has cos_present clear and cos_value zero. Write the size
// register only while the pipeline is empty; values above MAX_EMBED act as MAX_EMBED.
`default_nettype none
module sinusoidal_position_encoding_top #(
  parameter int unsigned MAX_EMBED     = spe_pkg::DEF_MAX_EMBED,
  parameter int unsigned POS_BITS      = spe_pkg::DEF_POS_BITS,
  parameter int unsigned OUT_FRAC_BITS = spe_pkg::DEF_OUT_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [spe_pkg::CFG_W-1:0]   cfg_wdata,
  spe_in_if.sink                      in_ch,
  spe_out_if.source                   out_ch
);
  import spe_pkg::*;
  localparam int unsigned DW     = $clog2(MAX_EMBED + 1);
  localparam int unsigned OW     = OUT_FRAC_BITS + 1;
  localparam int unsigned SH     = 32 - OUT_FRAC_BITS;
  localparam int unsigned NEXP   = EXP_TERMS - 1;
  localparam logic [61:0] HALF_Q = 62'h2000_0000_0000_0000;
  localparam logic [62:0] QUART  = 63'h4000_0000_0000_0000;

  typedef struct packed {
    logic err;
    logic cpres;
  } flags_t;

  typedef struct packed {
    logic [1:0] quad;
    logic       swap;
  } octant_t;

  typedef struct packed {
    logic [POS_BITS-1:0] j;
    flags_t              fl;
  } dside_t;

  typedef struct packed {
    logic [3:0]          ti;
    logic [POS_BITS-1:0] j;
    flags_t              fl;
  } eside_t;

  function automatic logic [32:0] clamp_unit(input logic signed [SUM_W-1:0] v);
    logic [32:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({{(SUM_W-33){1'b0}}, ONE32})) begin
      r = ONE32;
    end else begin
      r = v[32:0];
    end
    return r;
  endfunction

  function automatic logic [OW-1:0] to_out(input logic signed [33:0] v);
    logic        neg;
    logic [33:0] m;
    logic [33:0] top;
    neg = v[33];
    m   = neg ? 34'(-v) : 34'(v);
    m   = (m + (34'd1 << (SH - 1))) >> SH;
    top = 34'd1 << OUT_FRAC_BITS;
    if (!neg && m > top - 34'd1) begin
      m = top - 34'd1;
    end
    if (neg && m > top) begin
      m = top;
    end
    m = neg ? 34'(-m) : m;
    return m[OW-1:0];
  endfunction

  logic adv;
  logic vo_r;
  logic [CFG_W-1:0] cfg_r;
  logic [DW-1:0]    d_eff;

  assign adv         = !vo_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (32'(cfg_r) > MAX_EMBED) begin
      d_eff = DW'(MAX_EMBED);
    end else begin
      d_eff = DW'(cfg_r);
    end
  end

  // input register
  logic                vi_r;
  logic [POS_BITS-1:0] ji_r;
  logic [K_W-1:0]      ki_r;
  logic [K_W:0]        two_k;
  flags_t              fl_i;
  dside_t              dside_in, dside_out;
  logic                vd;
  logic [31:0]         e_d;

  always_comb begin
    two_k      = {ki_r, 1'b0};
    fl_i.err   = 32'(two_k) >= 32'(d_eff);
    fl_i.cpres = (32'(two_k) + 32'd1) < 32'(d_eff);
    dside_in.j  = ji_r;
    dside_in.fl = fl_i;
  end

  spe_divider #(
    .DW     (DW),
    .SIDE_W ($bits(dside_t))
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .v_in     (vi_r),
    .num      (DW'(two_k)),
    .den      (d_eff),
    .side_in  (dside_in),
    .v_out    (vd),
    .quo      (e_d),
    .side_out (dside_out)
  );

  // exponent to scale
  logic        vt_r, vy_r;
  logic [3:0]  tit_r, tiy_r;
  logic [31:0] ft_r, y_r;
  dside_t      dst_r, dsy_r;
  logic [63:0] prod_t, prod_y;

  assign prod_t = {32'b0, e_d} * {32'b0, L2T};
  assign prod_y = {32'b0, ft_r} * {32'b0, LN2};

  logic                    ev   [0:NEXP];
  logic [31:0]             eterm[0:NEXP];
  logic [31:0]             eop  [0:NEXP];
  logic signed [SUM_W-1:0] esum [0:NEXP];
  eside_t                  eside[0:NEXP];

  assign ev[0]       = vy_r;
  assign eterm[0]    = y_r;
  assign eop[0]      = y_r;
  assign esum[0]     = $signed({{(SUM_W-33){1'b0}}, ONE32})
                     - $signed({{(SUM_W-32){1'b0}}, y_r});
  assign eside[0].ti = tiy_r;
  assign eside[0].j  = dsy_r.j;
  assign eside[0].fl = dsy_r.fl;

  for (genvar g = 0; g < NEXP; g++) begin : g_exp
    spe_taylor_step #(
      .DIV    (g + 2),
      .NEG    (((g + 2) % 2) == 1),
      .SIDE_W ($bits(eside_t))
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .v_in     (ev[g]),
      .term_in  (eterm[g]),
      .op_in    (eop[g]),
      .sum_in   (esum[g]),
      .side_in  (eside[g]),
      .v_out    (ev[g+1]),
      .term_out (eterm[g+1]),
      .op_out   (eop[g+1]),
      .sum_out  (esum[g+1]),
      .side_out (eside[g+1])
    );
  end

  // scale, angle rate and phase
  logic                vs_r, vu1_r, vu2_r, vp1_r, vp2_r, vf_r, va_r, va2_r;
  logic [32:0]         s_r;
  logic [63:0]         m1_r, u_r, plo_r, p_r;
  logic [31:0]         m2_r, phi_r, a_r, aa_r, a2_r;
  logic [61:0]         rf_r;
  logic [POS_BITS-1:0] js_r, ju1_r, ju2_r;
  flags_t              fls_r, flu1_r, flu2_r, flp1_r, flp2_r, flf_r, fla_r, fla2_r;
  octant_t             oct_f_r, oct_a_r, oct_a2_r;
  logic [32:0]         x_s;
  logic [63:0]         prod_m1, prod_m2, prod_lo, prod_aa;
  logic [65:0]         prod_ang;
  logic [61:0]         r_f;
  logic                swap_f;

  always_comb begin
    x_s      = clamp_unit(esum[NEXP]);
    prod_m1  = {31'b0, s_r} * {32'b0, KH};
    prod_m2  = {31'b0, s_r} * {32'b0, KL};
    prod_lo  = 64'(ju2_r) * 64'(u_r[31:0]);
    r_f      = p_r[61:0];
    swap_f   = r_f > HALF_Q;
    prod_ang = {34'b0, rf_r[61:30]} * {33'b0, HPI};
    prod_aa  = {32'b0, a_r} * {32'b0, a_r};
  end

  // sine and cosine series
  logic                    sv   [0:TRIG_STEPS];
  logic [31:0]             sterm[0:TRIG_STEPS];
  logic [31:0]             sop  [0:TRIG_STEPS];
  logic signed [SUM_W-1:0] ssum [0:TRIG_STEPS];
  flags_t                  sside[0:TRIG_STEPS];
  logic                    cv   [0:TRIG_STEPS];
  logic [31:0]             cterm[0:TRIG_STEPS];
  logic [31:0]             cop  [0:TRIG_STEPS];
  logic signed [SUM_W-1:0] csum [0:TRIG_STEPS];
  octant_t                 cside[0:TRIG_STEPS];

  assign sv[0]    = va2_r;
  assign sterm[0] = aa_r;
  assign sop[0]   = a2_r;
  assign ssum[0]  = $signed({{(SUM_W-32){1'b0}}, aa_r});
  assign sside[0] = fla2_r;
  assign cv[0]    = va2_r;
  assign cterm[0] = {1'b0, a2_r[31:1]};
  assign cop[0]   = a2_r;
  assign csum[0]  = $signed({{(SUM_W-33){1'b0}}, ONE32})
                  - $signed({{(SUM_W-31){1'b0}}, a2_r[31:1]});
  assign cside[0] = oct_a2_r;

  for (genvar g = 0; g < TRIG_STEPS; g++) begin : g_trig
    spe_taylor_step #(
      .DIV    ((2 * g + 2) * (2 * g + 3)),
      .NEG    ((g % 2) == 0),
      .SIDE_W ($bits(flags_t))
    ) u_sin (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .v_in     (sv[g]),
      .term_in  (sterm[g]),
      .op_in    (sop[g]),
      .sum_in   (ssum[g]),
      .side_in  (sside[g]),
      .v_out    (sv[g+1]),
      .term_out (sterm[g+1]),
      .op_out   (sop[g+1]),
      .sum_out  (ssum[g+1]),
      .side_out (sside[g+1])
    );
    spe_taylor_step #(
      .DIV    ((g == 0) ? 0 : (2 * g + 1) * (2 * g + 2)),
      .NEG    ((g % 2) == 0),
      .SIDE_W ($bits(octant_t))
    ) u_cos (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .v_in     (cv[g]),
      .term_in  (cterm[g]),
      .op_in    (cop[g]),
      .sum_in   (csum[g]),
      .side_in  (cside[g]),
      .v_out    (cv[g+1]),
      .term_out (cterm[g+1]),
      .op_out   (cop[g+1]),
      .sum_out  (csum[g+1]),
      .side_out (cside[g+1])
    );
  end

  // quadrant placement and output formatting
  logic               vq_r;
  logic signed [33:0] so_r, co_r;
  flags_t             flq_r;
  logic [32:0]        sa_q, ca_q, sp_q, cp_q;
  logic signed [33:0] sps_q, cps_q, so_q, co_q;
  octant_t            oct_q;
  logic [OW-1:0]      sin_o_r, cos_o_r;
  logic               cpres_o_r, err_o_r;

  always_comb begin
    sa_q  = clamp_unit(ssum[TRIG_STEPS]);
    ca_q  = clamp_unit(csum[TRIG_STEPS]);
    oct_q = cside[TRIG_STEPS];
    sp_q  = oct_q.swap ? ca_q : sa_q;
    cp_q  = oct_q.swap ? sa_q : ca_q;
    sps_q = $signed({1'b0, sp_q});
    cps_q = $signed({1'b0, cp_q});
    case (oct_q.quad)
      2'd0: begin
        so_q = sps_q;
        co_q = cps_q;
      end
      2'd1: begin
        so_q = cps_q;
        co_q = -sps_q;
      end
      2'd2: begin
        so_q = -sps_q;
        co_q = -cps_q;
      end
      default: begin
        so_q = -cps_q;
        co_q = sps_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vi_r  <= 1'b0;
      vt_r  <= 1'b0;
      vy_r  <= 1'b0;
      vs_r  <= 1'b0;
      vu1_r <= 1'b0;
      vu2_r <= 1'b0;
      vp1_r <= 1'b0;
      vp2_r <= 1'b0;
      vf_r  <= 1'b0;
      va_r  <= 1'b0;
      va2_r <= 1'b0;
      vq_r  <= 1'b0;
      vo_r  <= 1'b0;
    end else if (adv) begin
      vi_r  <= in_ch.valid;
      vt_r  <= vd;
      vy_r  <= vt_r;
      vs_r  <= ev[NEXP];
      vu1_r <= vs_r;
      vu2_r <= vu1_r;
      vp1_r <= vu2_r;
      vp2_r <= vp1_r;
      vf_r  <= vp2_r;
      va_r  <= vf_r;
      va2_r <= va_r;
      vq_r  <= sv[TRIG_STEPS] && cv[TRIG_STEPS];
      vo_r  <= vq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ji_r     <= in_ch.position;
      ki_r     <= in_ch.pair_index;
      tit_r    <= prod_t[63:60];
      ft_r     <= prod_t[59:28];
      dst_r    <= dside_out;
      y_r      <= prod_y[63:32];
      tiy_r    <= tit_r;
      dsy_r    <= dst_r;
      s_r      <= x_s >> eside[NEXP].ti;
      js_r     <= eside[NEXP].j;
      fls_r    <= eside[NEXP].fl;
      m1_r     <= prod_m1;
      m2_r     <= prod_m2[63:32];
      ju1_r    <= js_r;
      flu1_r   <= fls_r;
      u_r      <= m1_r + {32'b0, m2_r};
      ju2_r    <= ju1_r;
      flu2_r   <= flu1_r;
      plo_r    <= prod_lo;
      phi_r    <= 32'(ju2_r) * u_r[63:32];
      flp1_r   <= flu2_r;
      p_r      <= plo_r + {phi_r, 32'b0};
      flp2_r   <= flp1_r;
      rf_r     <= swap_f ? 62'(QUART - {1'b0, r_f}) : r_f;
      oct_f_r  <= '{quad: p_r[63:62], swap: swap_f};
      flf_r    <= flp2_r;
      a_r      <= prod_ang[63:32];
      oct_a_r  <= oct_f_r;
      fla_r    <= flf_r;
      aa_r     <= a_r;
      a2_r     <= prod_aa[63:32];
      oct_a2_r <= oct_a_r;
      fla2_r   <= fla_r;
      so_r     <= so_q;
      co_r     <= co_q;
      flq_r    <= sside[TRIG_STEPS];
      err_o_r   <= flq_r.err;
      cpres_o_r <= !flq_r.err && flq_r.cpres;
      sin_o_r   <= flq_r.err ? '0 : to_out(so_r);
      cos_o_r   <= (flq_r.err || !flq_r.cpres) ? '0 : to_out(co_r);
    end
  end

  assign out_ch.valid       = vo_r;
  assign out_ch.sin_value   = sin_o_r;
  assign out_ch.cos_value   = cos_o_r;
  assign out_ch.cos_present = cpres_o_r;
  assign out_ch.index_error = err_o_r;

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r && err_o_r |-> sin_o_r == '0 && cos_o_r == '0 && !cpres_o_r)
    else $error("index error result carries data");
  a_cos_absent: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r && !cpres_o_r |-> cos_o_r == '0)
    else $error("absent cosine is not zero");
  a_scale_unit: assert property (@(posedge clk) disable iff (!rst_n)
    vs_r |-> s_r <= ONE32)
    else $error("frequency scale above one");
  a_fold_octant: assert property (@(posedge clk) disable iff (!rst_n)
    vf_r |-> rf_r <= HALF_Q)
    else $error("folded phase beyond an eighth turn");
`endif
endmodule
`default_nettype wire
